### sv/btpc_pkg.sv
// shared types, constants and helpers for the barometric compensation block
package btpc_pkg;

   localparam int unsigned RAW_W   = 19;
   localparam int unsigned CSR_W   = 64;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [31:0] B6_OFFSET   = 32'd4000;
   localparam logic [31:0] B4_BIAS     = 32'd32768;
   localparam logic [31:0] B7_SCALE    = 32'd50000;
   localparam logic [31:0] P_COEF_A    = 32'd3038;
   localparam logic [31:0] P_COEF_B    = 32'd7357;
   localparam logic [31:0] P_COEF_C    = 32'd3791;
   localparam logic [31:0] T_OFFSET    = 32'd15;
   localparam logic [5:0]  DIV_STEPS   = 6'd32;

   typedef enum logic [1:0] {
      CSR_CAL_FIRST    = 2'd0,
      CSR_CAL_SECOND   = 2'd1,
      CSR_CAL_THIRD    = 2'd2,
      CSR_OVERSAMPLING = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_T_X1,
      OP_T_DIV,
      OP_T_FIN,
      OP_P_B6,
      OP_P_SQ,
      OP_P_X1,
      OP_P_X3,
      OP_P_B3,
      OP_P_C1,
      OP_P_C2,
      OP_P_B4,
      OP_P_B7,
      OP_P_DIV,
      OP_P_PQ,
      OP_P_T2,
      OP_P_C3,
      OP_P_C4,
      OP_P_FIN
   } op_type;

   typedef struct packed {
      logic div_done;
      logic out_full;
   } status_type;

   function automatic logic [31:0] sx16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr(logic [31:0] v, logic [4:0] s);
      return 32'($signed(v) >>> s);
   endfunction

endpackage

### sv/btpc_if.sv
// request and response channel interfaces
interface btpc_req_if;
   import btpc_pkg::*;
   logic             valid;
   logic             ready;
   logic             mode;
   logic [RAW_W-1:0] raw_value;
   modport source (output valid, output mode, output raw_value, input ready);
   modport sink   (input valid, input mode, input raw_value, output ready);
endinterface

interface btpc_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] value;
   logic        div_error;
   modport source (output valid, output kind, output value, output div_error, input ready);
   modport sink   (input valid, input kind, input value, input div_error, output ready);
endinterface

### sv/btpc_datapath.sv
// datapath: calibration registers, shared multiplier, serial divider, output register
module btpc_datapath
   import btpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  op_type           cmd,
   output status_type       status,
   input  logic             req_mode,
   input  logic [RAW_W-1:0] req_raw_value,
   input  logic             csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_write_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_kind,
   output logic [31:0]      rsp_value,
   output logic             rsp_div_error
);

   logic [63:0] cal_first_ff, cal_second_ff;
   logic [31:0] cal_third_ff;
   logic [1:0]  oss_ff;

   logic             mode_ff;
   logic [RAW_W-1:0] raw_ff;
   logic [31:0] b5_ff, x1_ff, x2_ff, x3_ff, b6_ff, sq_ff, b3_ff, b4_ff, b7_ff, p_ff;
   logic        err_ff, neg_ff;

   logic [31:0] div_q_ff, div_d_ff;
   logic [31:0] div_r_ff;
   logic [5:0]  div_cnt_ff;

   logic        out_valid_ff, out_kind_ff, out_err_ff;
   logic [31:0] out_value_ff;

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   logic [31:0] raw32, mul_a, mul_b, prod;
   logic [31:0] t_div, t_num, t_num_mag, t_div_mag, t_x2, t_b5, p_fin, b3_sum, b3_shl;
   logic [32:0] r_shift;

   assign ac1 = sx16(cal_first_ff[63:48]);
   assign ac2 = sx16(cal_first_ff[47:32]);
   assign ac3 = sx16(cal_first_ff[31:16]);
   assign ac4 = {16'd0, cal_first_ff[15:0]};
   assign ac5 = {16'd0, cal_second_ff[63:48]};
   assign ac6 = {16'd0, cal_second_ff[47:32]};
   assign b1  = sx16(cal_second_ff[31:16]);
   assign b2  = sx16(cal_second_ff[15:0]);
   assign mc  = sx16(cal_third_ff[31:16]);
   assign md  = sx16(cal_third_ff[15:0]);
   assign raw32 = {{(32-RAW_W){1'b0}}, raw_ff};

   // operand select for the one shared multiplier
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (cmd)
         OP_T_X1: begin mul_a = raw32 - ac6;    mul_b = ac5; end
         OP_P_SQ: begin mul_a = b6_ff;          mul_b = b6_ff; end
         OP_P_X1: begin mul_a = b2;             mul_b = sq_ff; end
         OP_P_X3: begin mul_a = ac2;            mul_b = b6_ff; end
         OP_P_C1: begin mul_a = ac3;            mul_b = b6_ff; end
         OP_P_C2: begin mul_a = b1;             mul_b = sq_ff; end
         OP_P_B4: begin mul_a = ac4;            mul_b = x3_ff + B4_BIAS; end
         OP_P_B7: begin mul_a = raw32 - b3_ff;  mul_b = B7_SCALE >> oss_ff; end
         OP_P_T2: begin mul_a = asr(p_ff, 5'd8); mul_b = asr(p_ff, 5'd8); end
         OP_P_C3: begin mul_a = x1_ff;          mul_b = P_COEF_A; end
         OP_P_C4: begin mul_a = P_COEF_B;       mul_b = p_ff; end
         default: ;
      endcase
   end

   assign prod = 32'(mul_a * mul_b);

   always_comb begin
      t_div     = x1_ff + md;
      t_num     = {mc[20:0], 11'd0};
      t_num_mag = t_num[31] ? 32'(-t_num) : t_num;
      t_div_mag = t_div[31] ? 32'(-t_div) : t_div;
      t_x2      = err_ff ? 32'd0 : (neg_ff ? 32'(-div_q_ff) : div_q_ff);
      t_b5      = x1_ff + t_x2;
      p_fin     = p_ff + asr(x1_ff + x2_ff + P_COEF_C, 5'd4);
      b3_sum    = (ac1 << 2) + x3_ff;
      b3_shl    = b3_sum << oss_ff;
      r_shift   = {div_r_ff, div_q_ff[31]};
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_first_ff  <= '0;
         cal_second_ff <= '0;
         cal_third_ff  <= '0;
         oss_ff        <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_CAL_FIRST:    cal_first_ff  <= csr_write_data;
            CSR_CAL_SECOND:   cal_second_ff <= csr_write_data;
            CSR_CAL_THIRD:    cal_third_ff  <= csr_write_data[31:0];
            CSR_OVERSAMPLING: oss_ff        <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd)
         OP_LOAD: begin
            mode_ff <= req_mode;
            raw_ff  <= req_raw_value;
         end
         OP_T_X1: x1_ff <= asr(prod, 5'd15);
         OP_T_DIV: begin
            err_ff <= (t_div == 32'd0);
            neg_ff <= t_num[31] ^ t_div[31];
         end
         OP_P_B6: b6_ff <= b5_ff - B6_OFFSET;
         OP_P_SQ: sq_ff <= asr(prod, 5'd12);
         OP_P_X1: x1_ff <= asr(prod, 5'd11);
         OP_P_X3: x3_ff <= x1_ff + asr(prod, 5'd11);
         OP_P_B3: b3_ff <= asr(b3_shl + 32'd2, 5'd2);
         OP_P_C1: x1_ff <= asr(prod, 5'd13);
         OP_P_C2: x3_ff <= asr(x1_ff + asr(prod, 5'd16) + 32'd2, 5'd2);
         OP_P_B4: b4_ff <= prod >> 15;
         OP_P_B7: b7_ff <= prod;
         OP_P_DIV: begin
            err_ff <= (b4_ff == 32'd0);
            neg_ff <= 1'b0;
         end
         OP_P_PQ: p_ff  <= b7_ff[31] ? {div_q_ff[30:0], 1'b0} : div_q_ff;
         OP_P_T2: x1_ff <= prod;
         OP_P_C3: x1_ff <= asr(prod, 5'd16);
         OP_P_C4: x2_ff <= asr(32'(-prod), 5'd16);
         default: ;
      endcase
   end

   // temperature intermediate b5
   always_ff @(posedge clock) begin
      if (reset) begin
         b5_ff <= '0;
      end else if (cmd == OP_T_FIN) begin
         b5_ff <= t_b5;
      end
   end

   // restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd == OP_T_DIV || cmd == OP_P_DIV) begin
         div_cnt_ff <= DIV_STEPS;
      end else if (div_cnt_ff != 6'd0) begin
         div_cnt_ff <= div_cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == OP_T_DIV) begin
         div_q_ff <= t_num_mag;
         div_d_ff <= t_div_mag;
         div_r_ff <= '0;
      end else if (cmd == OP_P_DIV) begin
         div_q_ff <= b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
         div_d_ff <= b4_ff;
         div_r_ff <= '0;
      end else if (div_cnt_ff != 6'd0) begin
         if (r_shift >= {1'b0, div_d_ff}) begin
            div_r_ff <= 32'(r_shift - {1'b0, div_d_ff});
            div_q_ff <= {div_q_ff[30:0], 1'b1};
         end else begin
            div_r_ff <= r_shift[31:0];
            div_q_ff <= {div_q_ff[30:0], 1'b0};
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd == OP_T_FIN || cmd == OP_P_FIN) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == OP_T_FIN) begin
         out_kind_ff  <= mode_ff;
         out_err_ff   <= err_ff;
         out_value_ff <= err_ff ? 32'd0 : asr(t_b5 + 32'd8, 5'd4) - T_OFFSET;
      end else if (cmd == OP_P_FIN) begin
         out_kind_ff  <= mode_ff;
         out_err_ff   <= err_ff;
         out_value_ff <= err_ff ? 32'd0 : p_fin;
      end
   end

   assign status.div_done = (div_cnt_ff == 6'd0);
   assign status.out_full = out_valid_ff;

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_value     = out_value_ff;
   assign rsp_div_error = out_err_ff;

endmodule

### sv/btpc_ctrl.sv
// controller: sequences the compensation steps for one word at a time
module btpc_ctrl
   import btpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_mode,
   output logic       req_ready,
   input  status_type status,
   output op_type     cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_T_X1, S_T_DIV, S_T_WAIT, S_T_FIN,
      S_P_B6, S_P_SQ, S_P_X1, S_P_X3, S_P_B3, S_P_C1, S_P_C2, S_P_B4, S_P_B7,
      S_P_DIV, S_P_WAIT, S_P_PQ, S_P_T2, S_P_C3, S_P_C4, S_P_FIN
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = OP_LOAD;
               state_in = req_mode ? S_P_B6 : S_T_X1;
            end
         end
         S_T_X1:  begin cmd = OP_T_X1;  state_in = S_T_DIV; end
         S_T_DIV: begin cmd = OP_T_DIV; state_in = S_T_WAIT; end
         S_T_WAIT: begin
            if (status.div_done) state_in = S_T_FIN;
         end
         S_T_FIN: begin
            if (!status.out_full) begin
               cmd      = OP_T_FIN;
               state_in = S_IDLE;
            end
         end
         S_P_B6:  begin cmd = OP_P_B6;  state_in = S_P_SQ; end
         S_P_SQ:  begin cmd = OP_P_SQ;  state_in = S_P_X1; end
         S_P_X1:  begin cmd = OP_P_X1;  state_in = S_P_X3; end
         S_P_X3:  begin cmd = OP_P_X3;  state_in = S_P_B3; end
         S_P_B3:  begin cmd = OP_P_B3;  state_in = S_P_C1; end
         S_P_C1:  begin cmd = OP_P_C1;  state_in = S_P_C2; end
         S_P_C2:  begin cmd = OP_P_C2;  state_in = S_P_B4; end
         S_P_B4:  begin cmd = OP_P_B4;  state_in = S_P_B7; end
         S_P_B7:  begin cmd = OP_P_B7;  state_in = S_P_DIV; end
         S_P_DIV: begin cmd = OP_P_DIV; state_in = S_P_WAIT; end
         S_P_WAIT: begin
            if (status.div_done) state_in = S_P_PQ;
         end
         S_P_PQ:  begin cmd = OP_P_PQ;  state_in = S_P_T2; end
         S_P_T2:  begin cmd = OP_P_T2;  state_in = S_P_C3; end
         S_P_C3:  begin cmd = OP_P_C3;  state_in = S_P_C4; end
         S_P_C4:  begin cmd = OP_P_C4;  state_in = S_P_FIN; end
         S_P_FIN: begin
            if (!status.out_full) begin
               cmd      = OP_P_FIN;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_temp_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && !req_mode) |=> state_ff == S_T_X1)
      else $error("temperature word did not start its sequence");
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd == OP_T_DIV || cmd == OP_P_DIV) |=> !status.div_done)
      else $error("divider not busy after start");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd == OP_T_FIN || cmd == OP_P_FIN) |-> !status.out_full)
      else $error("result written over a pending word");
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd == OP_T_FIN || cmd == OP_P_FIN) |=> (state_ff == S_IDLE && status.out_full))
      else $error("finish did not return to idle with a pending word");
`endif

endmodule

### sv/baro_temp_pressure_compensation.sv
// top level of the barometric temperature and pressure compensation block
//
//   channel   | dir | handshake     | payload
//   req_chan  | in  | valid / ready | mode, raw_value
//   rsp_chan  | out | valid / ready | kind, value, div_error
//   csr_*     | in  | write enable  | index (2 bits), data (64 bits)
//
// the time from the acceptance of a temperature or pressure word to the next
// acceptance is set by the 32-step restoring divider and the steps through the
// shared multiplier
// one word is worked on at a time; the next is taken as soon as its result sits
// in the output register, even while that result waits on rsp_chan
// reset is synchronous and clears the calibration registers, b5 and control
// a stalled result holds the sequencer only at its final step
module baro_temp_pressure_compensation
   import btpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   btpc_req_if.sink             req_chan,
   btpc_rsp_if.source           rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   op_type     cmd;      // step issued to the datapath
   status_type status;   // divider and output register state

   // sequencer
   btpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, calibration storage and result register
   btpc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_chan.mode),
      .req_raw_value    (req_chan.raw_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_kind         (rsp_chan.kind),
      .rsp_value        (rsp_chan.value),
      .rsp_div_error    (rsp_chan.div_error)
   );

endmodule
